// ===== rtl/keyed_id_set_hash_table_assert.svh =====
// Assertion macros used by the keyed id set hash table engine.
`ifndef KEYED_ID_SET_HASH_TABLE_ASSERT_SVH
`define KEYED_ID_SET_HASH_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define KIDH_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define KIDH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/kidh_pkg.sv =====
// Types and constants shared by the keyed id set hash table.
`default_nettype none
package kidh_pkg;

   localparam int KEY_W    = 16;
   localparam int ID_W     = 16;
   localparam int TOTAL_W  = 4;
   localparam int STATUS_W = 3;
   localparam int LIMIT_W  = 7;

   localparam logic [LIMIT_W-1:0] KEY_LIMIT_RESET = 7'd32;

   typedef enum logic {
      OP_ADD  = 1'b0,
      OP_LIST = 1'b1
   } kidh_op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_ADDED      = 3'd0,
      STAT_DUPLICATE  = 3'd1,
      STAT_TABLE_FULL = 3'd2,
      STAT_LIST_FULL  = 3'd3,
      STAT_FOUND      = 3'd4,
      STAT_NOT_FOUND  = 3'd5
   } kidh_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE_CHK,
      ST_SCAN,
      ST_APPEND,
      ST_EMIT,
      ST_LIST
   } kidh_state_type;

   typedef struct packed {
      logic [ID_W-1:0]    out_id;
      logic [TOTAL_W-1:0] id_total;
      kidh_status_type    status;
      logic               last;
   } kidh_result_type;

endpackage
`default_nettype wire

// ===== rtl/kidh_if.sv =====
// Valid/ready channel interfaces for requests, results and the key limit register.
`default_nettype none

interface kidh_req_if import kidh_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             op;
   logic [KEY_W-1:0] key;
   logic [ID_W-1:0]  new_id;

   modport source (output valid, output op, output key, output new_id, input ready);
   modport sink   (input valid, input op, input key, input new_id, output ready);
endinterface

interface kidh_rsp_if import kidh_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ID_W-1:0]     out_id;
   logic [TOTAL_W-1:0]  id_total;
   logic [STATUS_W-1:0] status;
   logic                last;

   modport source (output valid, output out_id, output id_total, output status,
                   output last, input ready);
   modport sink   (input valid, input out_id, input id_total, input status,
                   input last, output ready);
endinterface

interface kidh_csr_if import kidh_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LIMIT_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/kidh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module kidh_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== rtl/kidh_engine.sv =====
// Sequencer, probe and scan datapath, and the slot and id memories of the table.
`default_nettype none
`include "keyed_id_set_hash_table_assert.svh"
module kidh_engine import kidh_pkg::*; #(
   parameter int SLOTS       = 64,
   parameter int IDS_PER_KEY = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   kidh_req_if.sink                req_ch,
   input  wire logic [LIMIT_W-1:0] key_limit,
   output logic                    res_valid,
   input  wire logic               res_ready,
   output kidh_result_type         res
);

   localparam int IDX_W    = $clog2(SLOTS);
   localparam int PCNT_W   = $clog2(SLOTS + 1);
   localparam int CNT_W    = $clog2(IDS_PER_KEY + 1);
   localparam int ID_DEPTH = SLOTS * IDS_PER_KEY;
   localparam int ID_AW    = $clog2(ID_DEPTH);
   localparam int SLOT_W   = 1 + CNT_W + KEY_W;

   localparam logic [IDX_W-1:0]  LAST_SLOT  = IDX_W'(SLOTS - 1);
   localparam logic [PCNT_W-1:0] LAST_PROBE = PCNT_W'(SLOTS - 1);
   localparam logic [CNT_W-1:0]  LIST_MAX   = CNT_W'(IDS_PER_KEY);
   localparam logic [ID_AW-1:0]  ROW_SIZE   = ID_AW'(IDS_PER_KEY);

   kidh_state_type       state_ff, state_in;
   logic                 op_ff, op_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [ID_W-1:0]      nid_ff, nid_in;
   logic [IDX_W-1:0]     ptr_ff, ptr_in;
   logic [PCNT_W-1:0]    pcnt_ff, pcnt_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic [CNT_W-1:0]     i_ff, i_in;
   logic [ID_AW-1:0]     id_base_ff, id_base_in;
   logic                 new_ff, new_in;
   kidh_status_type      res_status_ff, res_status_in;
   logic [CNT_W-1:0]     res_total_ff, res_total_in;
   logic [IDX_W-1:0]     clr_ff, clr_in;
   logic [LIMIT_W-1:0]   keys_ff, keys_in;

   logic                 slot_we;
   logic [IDX_W-1:0]     slot_waddr, slot_raddr;
   logic [SLOT_W-1:0]    slot_wdata, slot_rdata;
   logic                 id_we;
   logic [ID_AW-1:0]     id_waddr, id_raddr;
   logic [ID_W-1:0]      id_rdata;

   logic                 rd_valid;
   logic [CNT_W-1:0]     rd_count;
   logic [KEY_W-1:0]     rd_key;
   logic [IDX_W:0]       home_raw;
   logic [IDX_W-1:0]     home;
   logic [IDX_W-1:0]     ptr_next;
   logic [ID_AW-1:0]     base_now;
   logic [CNT_W-1:0]     i_next;
   logic                 scan_last;
   logic                 slot_empty, slot_hit, probe_end;
   logic                 list_full, limit_hit;
   logic [KEY_W-1:0]     cmp_a, cmp_b;
   logic                 cmp_eq;

   kidh_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_slot_ram (
      .clock (clock),
      .we    (slot_we),
      .waddr (slot_waddr),
      .wdata (slot_wdata),
      .raddr (slot_raddr),
      .rdata (slot_rdata)
   );

   kidh_ram #(.WIDTH(ID_W), .DEPTH(ID_DEPTH)) u_id_ram (
      .clock (clock),
      .we    (id_we),
      .waddr (id_waddr),
      .wdata (nid_ff),
      .raddr (id_raddr),
      .rdata (id_rdata)
   );

   assign rd_valid = slot_rdata[SLOT_W-1];
   assign rd_count = slot_rdata[KEY_W +: CNT_W];
   assign rd_key   = slot_rdata[KEY_W-1:0];

   // Home slot: the low key bits, folded once into the table range.
   assign home_raw = {1'b0, req_ch.key[IDX_W-1:0]};
   assign home     = (home_raw >= (IDX_W+1)'(SLOTS)) ?
                     IDX_W'(home_raw - (IDX_W+1)'(SLOTS)) : home_raw[IDX_W-1:0];

   assign ptr_next  = (ptr_ff == LAST_SLOT) ? '0 : ptr_ff + 1'b1;
   assign base_now  = ID_AW'(ptr_ff) * ROW_SIZE;
   assign i_next    = i_ff + 1'b1;
   assign scan_last = (i_next == n_ff);

   // One equality comparator serves both the key probe and the id scan.
   assign cmp_a  = (state_ff == ST_PROBE_CHK) ? rd_key : id_rdata;
   assign cmp_b  = (state_ff == ST_PROBE_CHK) ? key_ff : nid_ff;
   assign cmp_eq = (cmp_a == cmp_b);

   assign slot_empty = !rd_valid;
   assign slot_hit   = rd_valid && cmp_eq;
   assign probe_end  = (pcnt_ff == LAST_PROBE);
   assign list_full  = (n_ff >= LIST_MAX);
   assign limit_hit  = (keys_ff >= key_limit);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_SLOT) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_ch.valid) state_in = ST_PROBE_CHK;
         end
         ST_PROBE_CHK: begin
            if (slot_empty) begin
               if (op_ff == OP_LIST || limit_hit) state_in = ST_EMIT;
               else state_in = ST_APPEND;
            end else if (slot_hit) begin
               if (rd_count == '0) begin
                  state_in = (op_ff == OP_LIST) ? ST_EMIT : ST_APPEND;
               end else begin
                  state_in = (op_ff == OP_LIST) ? ST_LIST : ST_SCAN;
               end
            end else if (probe_end) begin
               state_in = ST_EMIT;
            end
         end
         ST_SCAN: begin
            if (cmp_eq) state_in = ST_EMIT;
            else if (scan_last) state_in = ST_APPEND;
         end
         ST_APPEND: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (res_ready) state_in = ST_IDLE;
         end
         ST_LIST: begin
            if (res_ready && scan_last) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      op_in         = op_ff;
      key_in        = key_ff;
      nid_in        = nid_ff;
      ptr_in        = ptr_ff;
      pcnt_in       = pcnt_ff;
      n_in          = n_ff;
      i_in          = i_ff;
      id_base_in    = id_base_ff;
      new_in        = new_ff;
      res_status_in = res_status_ff;
      res_total_in  = res_total_ff;
      clr_in        = clr_ff;
      keys_in       = keys_ff;

      req_ch.ready  = 1'b0;
      slot_we       = 1'b0;
      slot_waddr    = ptr_ff;
      slot_wdata    = {1'b1, CNT_W'(n_ff + 1'b1), key_ff};
      slot_raddr    = ptr_ff;
      id_we         = 1'b0;
      id_waddr      = id_base_ff + ID_AW'(n_ff);
      id_raddr      = id_base_ff + ID_AW'(i_ff);

      res_valid     = 1'b0;
      res.out_id    = '0;
      res.id_total  = TOTAL_W'(res_total_ff);
      res.status    = res_status_ff;
      res.last      = 1'b1;

      case (state_ff)
         ST_CLEAR: begin
            slot_we    = 1'b1;
            slot_waddr = clr_ff;
            slot_wdata = '0;
            clr_in     = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            slot_raddr   = home;
            if (req_ch.valid) begin
               op_in   = req_ch.op;
               key_in  = req_ch.key;
               nid_in  = req_ch.new_id;
               ptr_in  = home;
               pcnt_in = '0;
               new_in  = 1'b0;
            end
         end
         ST_PROBE_CHK: begin
            id_raddr = base_now;
            if (slot_empty) begin
               id_base_in   = base_now;
               n_in         = '0;
               res_total_in = '0;
               if (op_ff == OP_LIST) begin
                  res_status_in = STAT_NOT_FOUND;
               end else if (limit_hit) begin
                  res_status_in = STAT_TABLE_FULL;
               end else begin
                  new_in = 1'b1;
               end
            end else if (slot_hit) begin
               id_base_in    = base_now;
               n_in          = rd_count;
               i_in          = '0;
               res_total_in  = '0;
               res_status_in = STAT_NOT_FOUND;
            end else if (probe_end) begin
               res_total_in  = '0;
               res_status_in = (op_ff == OP_LIST) ? STAT_NOT_FOUND : STAT_TABLE_FULL;
            end else begin
               ptr_in     = ptr_next;
               pcnt_in    = pcnt_ff + 1'b1;
               slot_raddr = ptr_next;
            end
         end
         ST_SCAN: begin
            if (cmp_eq) begin
               res_status_in = STAT_DUPLICATE;
               res_total_in  = n_ff;
            end else if (!scan_last) begin
               i_in     = i_next;
               id_raddr = id_base_ff + ID_AW'(i_next);
            end
         end
         ST_APPEND: begin
            if (list_full) begin
               res_status_in = STAT_LIST_FULL;
               res_total_in  = n_ff;
            end else begin
               id_we         = 1'b1;
               slot_we       = 1'b1;
               res_status_in = STAT_ADDED;
               res_total_in  = CNT_W'(n_ff + 1'b1);
               if (new_ff) keys_in = keys_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            res_valid = 1'b1;
         end
         ST_LIST: begin
            res_valid    = 1'b1;
            res.out_id   = id_rdata;
            res.id_total = TOTAL_W'(n_ff);
            res.status   = STAT_FOUND;
            res.last     = scan_last;
            if (res_ready && !scan_last) begin
               i_in     = i_next;
               id_raddr = id_base_ff + ID_AW'(i_next);
            end
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         keys_ff  <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         keys_ff  <= keys_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      nid_ff        <= nid_in;
      ptr_ff        <= ptr_in;
      pcnt_ff       <= pcnt_in;
      n_ff          <= n_in;
      i_ff          <= i_in;
      id_base_ff    <= id_base_in;
      new_ff        <= new_in;
      res_status_ff <= res_status_in;
      res_total_ff  <= res_total_in;
   end

   `KIDH_ASSERT_IMPLY(a_new_key_within_limit, clock, reset, (state_ff == ST_APPEND) && new_ff, keys_ff < key_limit, "new key claimed a slot at or above the key limit")
   `KIDH_ASSERT_IMPLY(a_id_write_in_row, clock, reset, id_we, n_ff < LIST_MAX, "id written past the end of its list")
   `KIDH_ASSERT_IMPLY(a_probe_bounded, clock, reset, state_ff == ST_PROBE_CHK, pcnt_ff < PCNT_W'(SLOTS), "probe ran past the whole table")
   `KIDH_ASSERT_NEXT(a_last_returns_idle, clock, reset, res_valid && res_ready && res.last, state_ff == ST_IDLE, "sequencer did not return to idle after the final result")

endmodule
`default_nettype wire

// ===== rtl/keyed_id_set_hash_table.sv =====
// Top level of the keyed id set hash table: key limit register, engine and result register.
//
// This block is a linear-probing hash table that maps a 16-bit key to a set of up to
// IDS_PER_KEY 16-bit ids kept in insertion order. An add (op 0) finds or claims the key's
// slot and appends new_id unless it is already present, giving one status result; a list
// (op 1) gives one result per stored id, the last one marked, or a single not-found result.
// New keys are refused once key_limit keys are in use or no empty slot is left on the
// probe run, and an id is refused once its list holds IDS_PER_KEY ids. After reset the
// block clears the slot memory and accepts no request meanwhile; key limit writes are
// taken at any time. Items are handled one at a time: once a request is accepted, the
// slot memory is probed one slot per cycle (P probes, one for the home slot plus one per
// occupied slot passed over). An add then scans any ids stored for the key one per
// cycle, appends new_id unless it is found or the add is refused, and hands its result
// on; a list hands on one id per cycle while the result channel takes them. The slot
// and id memories are each read at one address per cycle with registered read data,
// and one comparator is shared by the probe and the scan. A result register sits
// between the engine and the result channel, so the next request is taken while a
// finished result still waits for its transfer.
`default_nettype none
module keyed_id_set_hash_table import kidh_pkg::*; #(
   parameter int SLOTS       = 64,
   parameter int IDS_PER_KEY = 8
) (
   input  wire logic  clock,
   input  wire logic  reset,
   kidh_req_if.sink   req_ch,
   kidh_rsp_if.source rsp_ch,
   kidh_csr_if.sink   csr_ch
);

   logic [LIMIT_W-1:0] key_limit_ff, key_limit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   kidh_result_type    rsp_data_ff, rsp_data_in;

   logic               res_valid;
   logic               res_ready;
   kidh_result_type    res;

   kidh_engine #(
      .SLOTS       (SLOTS),
      .IDS_PER_KEY (IDS_PER_KEY)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .key_limit (key_limit_ff),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // The key limit register is always ready; a write is one transfer on the csr channel.
   assign csr_ch.ready = 1'b1;
   assign key_limit_in = csr_ch.valid ? csr_ch.data : key_limit_ff;

   // The result register takes a new result whenever it is empty or its current
   // result is leaving in this cycle.
   assign res_ready = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) rsp_data_in = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_limit_ff <= KEY_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_limit_ff <= key_limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_id   = rsp_data_ff.out_id;
   assign rsp_ch.id_total = rsp_data_ff.id_total;
   assign rsp_ch.status   = rsp_data_ff.status;
   assign rsp_ch.last     = rsp_data_ff.last;

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the keyed id set hash table, with its own table predictor.
`default_nettype none
module tb import kidh_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   // The table geometry matches the defaults of the block under test.
   localparam int SLOTS       = 64;
   localparam int IDS_PER_KEY = 8;
   // The watchdog limit leaves a wide margin for long probe runs, full lists under back
   // pressure and the clearing pass after reset.
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_REPORTS = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   kidh_req_if req_ch ();
   kidh_rsp_if rsp_ch ();
   kidh_csr_if csr_ch ();

   keyed_id_set_hash_table #(
      .SLOTS       (SLOTS),
      .IDS_PER_KEY (IDS_PER_KEY)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   // Shadow copy of the table contents, updated at each request transfer.
   logic [KEY_W-1:0]   tbl_key  [SLOTS];
   bit                 tbl_used [SLOTS];
   int                 tbl_count[SLOTS];
   logic [ID_W-1:0]    tbl_ids  [SLOTS][IDS_PER_KEY];
   int                 keys_held = 0;
   int                 key_limit_model = int'(KEY_LIMIT_RESET);

   // Results that the predictor has worked out and the result channel still owes.
   kidh_result_type    due_results[$];

   // Keys biased toward a few neighboring home slots, so that probe runs collide
   // and wrap from the top slot back to slot zero.
   logic [KEY_W-1:0]   key_pool[48];

   // Shared control between the request side, the result side and the tests.
   bit                 calm = 1'b0;       // no random gaps or stalls on either side while set
   int                 hold_cycles = 0;   // long receiver hold-off, counted by the monitor
   int                 mismatches = 0;
   int                 cycle_count = 0;
   int                 adds_sent = 0;
   int                 lists_sent = 0;
   int                 results_seen = 0;
   int                 status_seen[6];

   // Every input of the block starts at a known value.
   initial begin
      req_ch.valid  = 1'b0;
      req_ch.op     = OP_ADD;
      req_ch.key    = '0;
      req_ch.new_id = '0;
      rsp_ch.ready  = 1'b0;
      csr_ch.valid  = 1'b0;
      csr_ch.data   = '0;
      for (int s = 0; s < SLOTS; s++) begin
         tbl_used[s]  = 1'b0;
         tbl_count[s] = 0;
      end
   end

   // Walk the probe run of a key. The result is the slot that holds the key (hit set),
   // the first empty slot on the run (hit clear), or -1 when every slot holds another key.
   function automatic int locate_slot(input logic [KEY_W-1:0] key, output bit hit);
      int home;
      int s;
      int found;
      home  = int'(key) % SLOTS;
      found = -1;
      hit   = 1'b0;
      for (int p = 0; p < SLOTS && found < 0; p++) begin
         s = (home + p) % SLOTS;
         if (!tbl_used[s]) begin
            found = s;
         end else if (tbl_key[s] == key) begin
            found = s;
            hit   = 1'b1;
         end
      end
      return found;
   endfunction

   // Apply one request to the shadow table and queue the results it must produce.
   function automatic void compute_table_response(input kidh_op_type op,
                                                  input logic [KEY_W-1:0] key,
                                                  input logic [ID_W-1:0] id);
      kidh_result_type r;
      bit hit;
      bit dup;
      int slot;
      int n;
      slot     = locate_slot(key, hit);
      r        = '0;
      r.last   = 1'b1;
      if (op == OP_ADD) begin
         if (!hit && (slot < 0 || keys_held >= key_limit_model)) begin
            r.status = STAT_TABLE_FULL;
         end else begin
            if (!hit) begin
               tbl_used[slot]  = 1'b1;
               tbl_key[slot]   = key;
               tbl_count[slot] = 0;
               keys_held++;
            end
            n   = tbl_count[slot];
            dup = 1'b0;
            for (int i = 0; i < n; i++) begin
               if (tbl_ids[slot][i] == id) dup = 1'b1;
            end
            r.id_total = TOTAL_W'(n);
            // A duplicate is reported as such even when the list is already full.
            if (dup) begin
               r.status = STAT_DUPLICATE;
            end else if (n >= IDS_PER_KEY) begin
               r.status = STAT_LIST_FULL;
            end else begin
               tbl_ids[slot][n] = id;
               tbl_count[slot]  = n + 1;
               r.id_total       = TOTAL_W'(n + 1);
               r.status         = STAT_ADDED;
            end
         end
         due_results.push_back(r);
      end else if (!hit || tbl_count[slot] == 0) begin
         r.status = STAT_NOT_FOUND;
         due_results.push_back(r);
      end else begin
         n = tbl_count[slot];
         for (int i = 0; i < n; i++) begin
            r.out_id   = tbl_ids[slot][i];
            r.id_total = TOTAL_W'(n);
            r.status   = STAT_FOUND;
            r.last     = (i == n - 1);
            due_results.push_back(r);
         end
      end
   endfunction

   // A random key that the table does not hold yet.
   function automatic logic [KEY_W-1:0] fresh_key();
      logic [KEY_W-1:0] k;
      bit hit;
      do begin
         k = KEY_W'($urandom_range(0, 65535));
         void'(locate_slot(k, hit));
      end while (hit);
      return k;
   endfunction

   // Mix of clustered pool keys, keys already in the table and fully random keys.
   function automatic logic [KEY_W-1:0] pick_key();
      int roll;
      int s;
      roll = $urandom_range(0, 99);
      s    = $urandom_range(0, SLOTS - 1);
      if (roll < 45) return key_pool[$urandom_range(0, 47)];
      if (roll < 70 && tbl_used[s]) return tbl_key[s];
      if (roll < 70) return key_pool[$urandom_range(0, 47)];
      return KEY_W'($urandom_range(0, 65535));
   endfunction

   // Small id values repeat often and so produce duplicates; the rest span all 16 bits.
   function automatic logic [ID_W-1:0] pick_id();
      if ($urandom_range(0, 1) == 0) return ID_W'($urandom_range(0, 11));
      return ID_W'($urandom_range(0, 65535));
   endfunction

   // Offer one request after a random gap and return at the edge of its transfer.
   // Valid is left high, so the next call either keeps it up or lowers it for a gap.
   task automatic send_request(input kidh_op_type op, input logic [KEY_W-1:0] key,
                               input logic [ID_W-1:0] id);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 4);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.op     <= op;
      req_ch.key    <= key;
      req_ch.new_id <= id;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      compute_table_response(op, key, id);
      if (op == OP_ADD) adds_sent++;
      else lists_sent++;
   endtask

   // Stop offering requests and wait until every predicted result has been transferred.
   task automatic await_all_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
   endtask

   // Write the key limit register. Only called while the block is idle.
   task automatic write_key_limit(input logic [LIMIT_W-1:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      key_limit_model = int'(value);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Random adds and lists. Every so often both sides run without idle cycles for a
   // stretch, and now and then the sender waits for the block to drain completely.
   task automatic random_traffic(input int count, input int list_pct);
      kidh_op_type op;
      for (int i = 0; i < count; i++) begin
         if (i % 16 == 0) calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 39) == 0) await_all_results();
         op = ($urandom_range(0, 99) < list_pct) ? OP_LIST : OP_ADD;
         send_request(op, pick_key(), pick_id());
      end
      calm = 1'b0;
   endtask

   // Hand-picked cases at the default key limit: absent keys, duplicates, a list filled
   // to capacity, a duplicate offered to that full list, colliding home slots and a
   // probe run that wraps from the top slot around to slot zero.
   task automatic test_directed_cases();
      send_request(OP_LIST, 16'd0, 16'd0);           // key not present yet
      send_request(OP_ADD,  16'd0, 16'd0);
      send_request(OP_ADD,  16'd0, 16'd0);           // same id again
      send_request(OP_LIST, 16'd0, 16'hFFFF);
      send_request(OP_ADD,  16'd64, 16'hFFFF);       // shares home slot zero
      send_request(OP_ADD,  16'd128, 16'd7);
      send_request(OP_ADD,  16'd1, 16'd1);           // its home is taken by key 64
      send_request(OP_LIST, 16'd128, 16'd0);
      send_request(OP_ADD,  16'hFFFF, 16'hFFFF);     // home is the top slot
      send_request(OP_ADD,  16'd127, 16'd3);         // wraps past slot zero
      for (int i = 1; i < IDS_PER_KEY; i++) send_request(OP_ADD, 16'd0, ID_W'(i));
      send_request(OP_ADD,  16'd0, 16'd100);         // list of key 0 is already full
      send_request(OP_ADD,  16'd0, 16'd5);           // duplicate in a full list
      send_request(OP_LIST, 16'd0, 16'd0);
      send_request(OP_LIST, 16'd127, 16'h5A5A);
      send_request(OP_LIST, 16'hFFFF, 16'hFFFF);
      send_request(OP_LIST, 16'd192, 16'd0);         // absent, probes the whole cluster
      await_all_results();
   endtask

   // With a key limit of zero every new key is refused, while known keys still work.
   task automatic test_zero_limit();
      write_key_limit(LIMIT_W'(0));
      send_request(OP_ADD,  16'd5000, 16'd1);
      send_request(OP_ADD,  16'd64, 16'd9);
      send_request(OP_LIST, 16'd5000, 16'd0);
      send_request(OP_LIST, 16'd64, 16'd0);
      await_all_results();
   endtask

   // Broad random traffic at a mid-range limit.
   task automatic test_random_traffic();
      write_key_limit(LIMIT_W'(48));
      random_traffic(90, 35);
      await_all_results();
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering long
   // lists, so the result register and the engine fill and the request side stalls.
   task automatic test_backpressure();
      calm        = 1'b1;
      hold_cycles = 200;
      for (int i = 0; i < 12; i++) begin
         send_request(OP_LIST, (i % 3 == 2) ? 16'hFFFF : 16'd0, ID_W'(i));
      end
      calm = 1'b0;
      await_all_results();
   endtask

   // A limit of one is already exceeded, so new keys are refused and known keys work.
   task automatic test_single_key_limit();
      write_key_limit(LIMIT_W'(1));
      send_request(OP_ADD, fresh_key(), pick_id());
      random_traffic(12, 30);
      await_all_results();
   endtask

   // Fill every slot at the highest useful limit, check refusal at that limit, then raise
   // the limit past the slot count so that refusals come from the full table instead.
   task automatic test_fill_table();
      write_key_limit(LIMIT_W'(SLOTS));
      while (keys_held < SLOTS) send_request(OP_ADD, fresh_key(), pick_id());
      for (int i = 0; i < 3; i++) send_request(OP_ADD, fresh_key(), pick_id());
      await_all_results();
      write_key_limit(LIMIT_W'(127));
      for (int i = 0; i < 3; i++) send_request(OP_ADD, fresh_key(), pick_id());
      random_traffic(40, 45);
      await_all_results();
   endtask

   // Result side: random stalls per result, the long hold-off when asked, and a check of
   // every transfer against the oldest predicted result.
   initial begin : result_monitor
      kidh_result_type want;
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_cycles--;
         end else if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (rsp_ch.status < 6) status_seen[rsp_ch.status]++;
            if (due_results.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("Unexpected result: id %h total %0d status %0d last %b",
                           rsp_ch.out_id, rsp_ch.id_total, rsp_ch.status, rsp_ch.last);
               end
            end else begin
               want = due_results.pop_front();
               if (rsp_ch.out_id !== want.out_id || rsp_ch.id_total !== want.id_total ||
                   rsp_ch.status !== want.status || rsp_ch.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $display("Mismatch on result %0d: expected id %h total %0d status %0d",
                              results_seen, want.out_id, want.id_total, want.status,
                              " last %b, got id %h total %0d status %0d last %b",
                              want.last, rsp_ch.out_id, rsp_ch.id_total, rsp_ch.status,
                              rsp_ch.last);
                  end
               end
            end
            stall = calm ? 0 : $urandom_range(0, 4);
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, due_results.size());
         $display("tb: FAIL");
         $finish;
      end
   end

   // Test sequence. Reset is applied once; the block then clears its slot memory and
   // holds off requests, which the request handshake absorbs.
   initial begin
      int home;
      for (int i = 0; i < 48; i++) begin
         home        = $urandom_range(0, 11);
         home        = (home < 8) ? home : home + 52;
         key_pool[i] = {10'($urandom_range(0, 1023)), 6'(home)};
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_zero_limit();
      test_random_traffic();
      test_backpressure();
      test_single_key_limit();
      test_fill_table();

      // Any stray result after the last expected one is caught by the monitor here.
      await_all_results();
      repeat (100) @(posedge clock);

      $display("Covered %0d adds and %0d lists giving %0d results, key limits 0 to 127.",
               adds_sent, lists_sent, results_seen);
      $display("Statuses: added %0d, duplicate %0d, table full %0d, list full %0d,",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               " found %0d, not found %0d; %0d mismatches.",
               status_seen[4], status_seen[5], mismatches);
      if (mismatches == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== keyed_id_set_hash_table.f =====
+incdir+rtl
rtl/kidh_pkg.sv
rtl/kidh_if.sv
rtl/kidh_ram.sv
rtl/kidh_engine.sv
rtl/keyed_id_set_hash_table.sv
tb/sv/tb.sv
